// File: sv/atrp_pkg.sv
// Shared types, constants and the angle table for the accelerometer tilt block.
// Used by the CORDIC cell, the gain stage and the top level; depends on nothing.
package atrp_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STAGES   = 16;
  localparam int GUARD_BITS      = 8;
  localparam int TAB_FRAC_BITS   = 20;
  localparam int TAB_LEN         = 24;
  localparam int N_STAGES        = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  // Vector datapath and angle accumulator widths
  localparam int DW  = 28;
  localparam int AW  = 31;
  localparam int AWX = AW + 1;
  localparam int SHW = $clog2(TAB_LEN);

  // 1/K in Q30
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = GAIN_W'(652032874);

  localparam int OUT_SH = TAB_FRAC_BITS - ANGLE_FRAC_BITS;

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [AW-1:0] angle_t;

  typedef struct packed {
    logic               zero;
    logic signed [15:0] word;
  } carry_t;

  localparam angle_t HALF_TURN = angle_t'(180 * (2 ** TAB_FRAC_BITS));

  // atan(2^-i) in degrees, Q20
  localparam angle_t ATAN_TAB [TAB_LEN] = '{
    angle_t'(47185920), angle_t'(27855475), angle_t'(14718068), angle_t'(7471121),
    angle_t'(3750058),  angle_t'(1876857),  angle_t'(938658),   angle_t'(469357),
    angle_t'(234682),   angle_t'(117342),   angle_t'(58671),    angle_t'(29335),
    angle_t'(14668),    angle_t'(7334),     angle_t'(3667),     angle_t'(1833),
    angle_t'(917),      angle_t'(458),      angle_t'(229),      angle_t'(115),
    angle_t'(57),       angle_t'(29),       angle_t'(14),       angle_t'(7)
  };

  // Round half up to the output LSB, then clamp to +-limit_deg degrees.
  function automatic logic signed [15:0] round_sat(input angle_t ang, input int limit_deg);
    logic signed [AWX-1:0] sum;
    logic signed [AWX-1:0] r;
    logic signed [AWX-1:0] lim;
    sum = AWX'(ang) + AWX'(2 ** (OUT_SH - 1));
    r   = sum >>> OUT_SH;
    lim = AWX'(limit_deg * (2 ** ANGLE_FRAC_BITS));
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

endpackage

// File: sv/accel_tilt_roll_pitch.sv
// Top level of the accelerometer tilt block: input stage, two chains of CORDIC
// cells, the gain stage and the output register with skid. Depends on atrp_pkg.

// One sample (x, y, z) in gives roll = atan2(y, z) and pitch = atan2(-x, |(y, z)|)
// in degrees with 7 fraction bits. The block takes one sample per cycle and holds
// up to 36 in flight; each passes the input stage, 16 roll cells, the gain stage,
// 16 pitch cells and the output register. Each cell is one CORDIC micro-rotation
// with its own register, so the cell count sets the latency and one cell sets the
// clock. The skid register at the output takes one more result while the output is
// stalled; the input stalls only while that skid register is full.
module accel_tilt_roll_pitch (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle
);
  import atrp_pkg::*;

  logic adv;
  logic out_free;

  // input stage
  data_t  x1;
  data_t  y1;
  angle_t base;
  carry_t carry1;

  // roll chain
  logic   rv [N_STAGES+1];
  data_t  rx [N_STAGES+1];
  data_t  ry [N_STAGES+1];
  angle_t ra [N_STAGES+1];
  carry_t rc [N_STAGES+1];

  // gain stage
  logic               gv;
  data_t              gx;
  data_t              gy;
  logic signed [15:0] groll;

  // pitch chain
  logic   pv [N_STAGES+1];
  data_t  px [N_STAGES+1];
  data_t  py [N_STAGES+1];
  angle_t pa [N_STAGES+1];
  carry_t pc [N_STAGES+1];

  logic               res_valid;
  logic signed [15:0] res_roll;
  logic signed [15:0] res_pitch_full;
  logic signed [14:0] res_pitch;

  logic               skid_valid;
  logic signed [15:0] skid_roll;
  logic signed [14:0] skid_pitch;

  assign adv      = !skid_valid;
  assign in_stall = skid_valid;
  assign out_free = !out_valid || !out_stall;

  // Fold the (z, y) vector into the right half plane.
  always_comb begin
    x1 = data_t'(accel_z) <<< GUARD_BITS;
    y1 = data_t'(accel_y) <<< GUARD_BITS;
    base = '0;
    if (accel_z[15]) begin
      x1   = -x1;
      y1   = -y1;
      base = accel_y[15] ? -HALF_TURN : HALF_TURN;
    end
    carry1.zero = (accel_z == 16'sd0) && (accel_y == 16'sd0);
    carry1.word = accel_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (adv) begin
      rv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx[0] <= x1;
      ry[0] <= y1;
      ra[0] <= base;
      rc[0] <= carry1;
    end
  end

  for (genvar i = 0; i < N_STAGES; i++) begin : g_roll
    atrp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (rv[i]),
      .x_in      (rx[i]),
      .y_in      (ry[i]),
      .ang_in    (ra[i]),
      .carry_in  (rc[i]),
      .shift     (SHW'(i)),
      .step      (ATAN_TAB[i]),
      .out_valid (rv[i+1]),
      .x_out     (rx[i+1]),
      .y_out     (ry[i+1]),
      .ang_out   (ra[i+1]),
      .carry_out (rc[i+1])
    );
  end

  atrp_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (rv[N_STAGES]),
    .x_in      (rx[N_STAGES]),
    .ang_in    (ra[N_STAGES]),
    .carry_in  (rc[N_STAGES]),
    .out_valid (gv),
    .x2        (gx),
    .y2        (gy),
    .roll_q    (groll)
  );

  assign pv[0]      = gv;
  assign px[0]      = gx;
  assign py[0]      = gy;
  assign pa[0]      = '0;
  assign pc[0].zero = (gx == '0) && (gy == '0);
  assign pc[0].word = groll;

  for (genvar i = 0; i < N_STAGES; i++) begin : g_pitch
    atrp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (pv[i]),
      .x_in      (px[i]),
      .y_in      (py[i]),
      .ang_in    (pa[i]),
      .carry_in  (pc[i]),
      .shift     (SHW'(i)),
      .step      (ATAN_TAB[i]),
      .out_valid (pv[i+1]),
      .x_out     (px[i+1]),
      .y_out     (py[i+1]),
      .ang_out   (pa[i+1]),
      .carry_out (pc[i+1])
    );
  end

  always_comb begin
    res_valid      = pv[N_STAGES];
    res_roll       = pc[N_STAGES].word;
    res_pitch_full = pc[N_STAGES].zero ? 16'sd0 : round_sat(pa[N_STAGES], 90);
    res_pitch      = res_pitch_full[14:0];
  end

  // Output register plus skid: park a result in the skid register when the
  // output is stalled, and hold the chain until it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        roll_angle  <= skid_roll;
        pitch_angle <= skid_pitch;
      end
    end else if (res_valid) begin
      if (out_free) begin
        roll_angle  <= res_roll;
        pitch_angle <= res_pitch;
      end else begin
        skid_roll  <= res_roll;
        skid_pitch <= res_pitch;
      end
    end
  end

endmodule

// File: sv/atrp_cell.sv
// One CORDIC vectoring stage with its pipeline register.
// Depends on atrp_pkg; shift amount and table step arrive as tied-off ports.
module atrp_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  atrp_pkg::data_t          x_in,
  input  atrp_pkg::data_t          y_in,
  input  atrp_pkg::angle_t         ang_in,
  input  atrp_pkg::carry_t         carry_in,
  input  logic [atrp_pkg::SHW-1:0] shift,
  input  atrp_pkg::angle_t         step,
  output logic                     out_valid,
  output atrp_pkg::data_t          x_out,
  output atrp_pkg::data_t          y_out,
  output atrp_pkg::angle_t         ang_out,
  output atrp_pkg::carry_t         carry_out
);
  import atrp_pkg::*;

  data_t  xs;
  data_t  ys;
  data_t  x_next;
  data_t  y_next;
  angle_t ang_next;

  always_comb begin
    xs = x_in >>> shift;
    ys = y_in >>> shift;
    if (!y_in[DW-1]) begin
      x_next   = x_in + ys;
      y_next   = y_in - xs;
      ang_next = ang_in + step;
    end else begin
      x_next   = x_in - ys;
      y_next   = y_in + xs;
      ang_next = ang_in - step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out     <= x_next;
      y_out     <= y_next;
      ang_out   <= ang_next;
      carry_out <= carry_in;
    end
  end

endmodule

// File: sv/atrp_gain.sv
// Stage between the two CORDIC passes: removes the CORDIC gain from the roll
// magnitude, builds the pitch vector and rounds the roll angle. Depends on atrp_pkg.
module atrp_gain (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  atrp_pkg::data_t   x_in,
  input  atrp_pkg::angle_t  ang_in,
  input  atrp_pkg::carry_t  carry_in,
  output logic              out_valid,
  output atrp_pkg::data_t   x2,
  output atrp_pkg::data_t   y2,
  output logic signed [15:0] roll_q
);
  import atrp_pkg::*;

  localparam int MW = DW - 1;
  localparam int PW = MW + GAIN_W;

  logic [PW-1:0]      mag_ext;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      prod_rnd;
  data_t              x2_next;
  data_t              y2_next;
  logic signed [15:0] roll_next;

  always_comb begin
    // clamp a negative magnitude to zero
    mag_ext   = x_in[DW-1] ? '0 : PW'(x_in[MW-1:0]);
    prod      = mag_ext * PW'(INV_GAIN_Q30);
    prod_rnd  = prod + (PW'(1) << (GAIN_W - 1));
    x2_next   = data_t'({1'b0, prod_rnd[PW-1:GAIN_W]});
    y2_next   = -(data_t'(carry_in.word) <<< GUARD_BITS);
    roll_next = carry_in.zero ? 16'sd0 : round_sat(ang_in, 180);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2     <= x2_next;
      y2     <= y2_next;
      roll_q <= roll_next;
    end
  end

endmodule
